### rtl/core/fsg_pkg.sv
// fsg_pkg: shared types for the falling sand grid update block
// material codes, engine states and the command and result structs
// no dependencies
package fsg_pkg;

  typedef enum logic [1:0] {
    MAT_EMPTY = 2'd0,
    MAT_SAND  = 2'd1,
    MAT_WATER = 2'd2
  } mat_e;

  typedef enum logic {
    FUNC_FRAME = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    CAND_BELOW = 2'd0,
    CAND_LEFT  = 2'd1,
    CAND_RIGHT = 2'd2
  } cand_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_RDONE,
    ST_PAINT,
    ST_FETCH,
    ST_CUR,
    ST_CAND,
    ST_MOVE,
    ST_DONE
  } eng_state_e;

  typedef struct packed {
    func_e func;
    logic  row_ok;
    logic  paint_sand;
    logic  paint_water;
  } cmd_t;

  typedef struct packed {
    mat_e material;
    logic frame_done;
  } res_t;

endpackage

### rtl/core/fsg_engine.sv
// fsg_engine: grid memory with clearing pass, paint, in-place sweep and cell read
// one synchronous ram with a registered read port, driven by a read-modify-write sequencer
// depends on fsg_pkg
module fsg_engine import fsg_pkg::*; #(
  parameter int unsigned GRID_SIDE = 64,
  localparam int unsigned CW = $clog2(GRID_SIDE)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  cmd_t          cmd_i,
  input  logic [CW-1:0] cmd_col_i,
  input  logic [CW-1:0] cmd_row_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output res_t          res_o
);

  localparam int unsigned CELLS = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned START = CELLS - GRID_SIDE - 1;

  logic [1:0] mem [CELLS];
  logic [1:0] rdata_q;

  eng_state_e    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] idx_q, idx_d;
  cmd_t          cmd_q, cmd_d;
  logic [AW-1:0] i_q, i_d;
  logic [CW-1:0] col_q, col_d;
  mat_e          mat_q, mat_d;
  cand_e         cand_q, cand_d;

  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  mat_e          wd;
  mat_e          cur;
  logic          fits;
  logic          has_left;
  logic          has_right;
  logic [AW-1:0] i_dec;
  logic [CW-1:0] col_dec;
  logic [AW-1:0] cmd_idx;

  function automatic logic [AW-1:0] cand_addr(cand_e c, mat_e m, logic [AW-1:0] i);
    logic [AW-1:0] below;
    logic [AW-1:0] base;
    logic [AW-1:0] r;
    below = i + AW'(GRID_SIDE);
    base  = (m == MAT_SAND) ? below : i;
    case (c)
      CAND_BELOW: r = below;
      CAND_LEFT:  r = base - AW'(1);
      CAND_RIGHT: r = base + AW'(1);
      default:    r = below;
    endcase
    return r;
  endfunction

  assign cmd_idx   = AW'(AW'(cmd_row_i) * AW'(GRID_SIDE)) + AW'(cmd_col_i);
  assign cur       = mat_e'(rdata_q);
  assign has_left  = (col_q != '0);
  assign has_right = (col_q != CW'(GRID_SIDE - 1));
  assign i_dec     = i_q - AW'(1);
  assign col_dec   = (col_q == '0) ? CW'(GRID_SIDE - 1) : col_q - CW'(1);
  assign fits      = (mat_q == MAT_SAND) ? (cur != MAT_SAND) : (cur == MAT_EMPTY);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cmd_q  <= cmd_d;
    i_q    <= i_d;
    col_q  <= col_d;
    mat_q  <= mat_d;
    cand_q <= cand_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    i_d         = i_q;
    col_d       = col_q;
    mat_d       = mat_q;
    cand_d      = cand_q;
    rd_addr     = idx_q;
    we          = 1'b0;
    wa          = i_q;
    wd          = MAT_EMPTY;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{material: MAT_EMPTY, frame_done: 1'b0};

    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          idx_d   = cmd_idx;
          state_d = (cmd_i.func == FUNC_READ) ? ST_READ : ST_PAINT;
        end
      end
      ST_READ: begin
        state_d = ST_RDONE;
      end
      ST_RDONE: begin
        res_valid_o    = 1'b1;
        res_o.material = cmd_q.row_ok ? cur : MAT_EMPTY;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_PAINT: begin
        wa = idx_q;
        wd = cmd_q.paint_water ? MAT_WATER : MAT_SAND;
        we = cmd_q.row_ok && (cmd_q.paint_sand || cmd_q.paint_water);
        i_d     = AW'(START);
        col_d   = CW'(GRID_SIDE - 1);
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        rd_addr = i_q;
        state_d = ST_CUR;
      end
      ST_CUR: begin
        mat_d = cur;
        if (cur == MAT_SAND || cur == MAT_WATER) begin
          cand_d  = CAND_BELOW;
          rd_addr = cand_addr(CAND_BELOW, cur, i_q);
          state_d = ST_CAND;
        end else if (i_q == '0) begin
          state_d = ST_DONE;
        end else begin
          i_d     = i_dec;
          col_d   = col_dec;
          rd_addr = i_dec;
        end
      end
      ST_CAND: begin
        if (fits) begin
          we      = 1'b1;
          wa      = cand_addr(cand_q, mat_q, i_q);
          wd      = mat_q;
          state_d = ST_MOVE;
        end else if (cand_q == CAND_BELOW && has_left) begin
          cand_d  = CAND_LEFT;
          rd_addr = cand_addr(CAND_LEFT, mat_q, i_q);
        end else if (cand_q != CAND_RIGHT && has_right) begin
          cand_d  = CAND_RIGHT;
          rd_addr = cand_addr(CAND_RIGHT, mat_q, i_q);
        end else if (i_q == '0) begin
          state_d = ST_DONE;
        end else begin
          i_d     = i_dec;
          col_d   = col_dec;
          rd_addr = i_dec;
          state_d = ST_CUR;
        end
      end
      ST_MOVE: begin
        we = 1'b1;
        wa = i_q;
        wd = MAT_EMPTY;
        if (i_q == '0) begin
          state_d = ST_DONE;
        end else begin
          i_d     = i_dec;
          col_d   = col_dec;
          rd_addr = i_dec;
          state_d = ST_CUR;
        end
      end
      ST_DONE: begin
        res_valid_o      = 1'b1;
        res_o.frame_done = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/falling_sand_grid_update_top.sv
// falling_sand_grid_update_top: stream ports, column wrap, row check and result register
// a read returns the addressed cell; a frame optionally paints that cell, then sweeps the grid
// ram in place, from the highest index above the bottom row down to index 0
// throughput: one transaction in work at a time, the next taken in the cycle after the result goes
// after reset every ram cell is cleared before the first transaction
// depends on fsg_pkg and fsg_engine
module falling_sand_grid_update_top import fsg_pkg::*; #(
  parameter int unsigned GRID_SIDE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // cell_x[5:0], cell_y[11:6], left_down[12], right_down[13]
  input  logic        s_axis_tuser_i,  // func[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // cell_material[1:0]
  output logic        m_axis_tuser_o   // frame_done[0]
);

  localparam int unsigned CW = $clog2(GRID_SIDE);

  logic [CW-1:0] col_lut [64];
  logic [5:0]    cell_x;
  logic [5:0]    cell_y;
  logic          row_ok;
  cmd_t          cmd;
  logic [CW-1:0] cmd_col;
  logic [CW-1:0] cmd_row;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  logic          out_valid_q, out_valid_d;
  res_t          out_res_q, out_res_d;

  for (genvar g = 0; g < 64; g++) begin : g_col_lut
    assign col_lut[g] = CW'(g % GRID_SIDE);
  end

  assign cell_x  = s_axis_tdata_i[5:0];
  assign cell_y  = s_axis_tdata_i[11:6];
  assign row_ok  = (32'(cell_y) < GRID_SIDE);
  assign cmd_col = col_lut[cell_x];
  assign cmd_row = CW'(cell_y);
  assign cmd     = '{func:        func_e'(s_axis_tuser_i),
                     row_ok:      row_ok,
                     paint_sand:  s_axis_tdata_i[12],
                     paint_water: s_axis_tdata_i[13]};

  fsg_engine #(
    .GRID_SIDE(GRID_SIDE)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(s_axis_tvalid_i),
    .cmd_ready_o(s_axis_tready_o),
    .cmd_i      (cmd),
    .cmd_col_i  (cmd_col),
    .cmd_row_i  (cmd_row),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_res_q.material};
  assign m_axis_tuser_o  = out_res_q.frame_done;

endmodule

### rtl/core/fsg_checker.sv
// fsg_checker: port-level assertions for the falling sand grid update block
// bound to falling_sand_grid_update_top; no other dependencies
module fsg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // a frame result carries no material
  a_frame_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 8'd0)
    else $error("frame result with non-zero material");

  // material code is legal and padding is zero
  a_mat_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != 2'd3 && m_axis_tdata_o[7:2] == 6'd0)
    else $error("illegal material code");

  // one transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second transaction taken while busy");

endmodule

bind falling_sand_grid_update_top fsg_checker u_fsg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

### sim/testbench.sv
// testbench: stream-level check of falling_sand_grid_update_top against a grid model
// a queue-fed driver, a checking monitor and a stalling receiver, all clocked at the rising edge
// depends on fsg_pkg and falling_sand_grid_update_top
module testbench;
  import fsg_pkg::*;

  localparam int unsigned SIDE = 64;
  localparam int unsigned CELLS = SIDE * SIDE;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    func_e      func;
    logic [5:0] col;
    logic [5:0] row;
    logic       sand;
    logic       water;
    bit         wait_idle;
    bit         hold_rx;
  } cell_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [15:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;
  logic        m_user;
  logic        rx_hold_req = 1'b0;
  int unsigned rx_hold_left = 0;

  cell_req_t   pending_cmds[$];
  res_t        expected_cells[$];
  mat_e        grid_model[CELLS];
  int unsigned n_sent = 0;
  int unsigned n_total = 1;
  int unsigned mismatch_count = 0;

  falling_sand_grid_update_top #(
    .GRID_SIDE(SIDE)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // in-place sweep, bottom row excluded, highest index first
  function automatic void sweep_grid();
    int unsigned col;
    int unsigned below;
    for (int i = CELLS - SIDE - 1; i >= 0; i--) begin
      col = i % SIDE;
      below = i + SIDE;
      if (grid_model[i] == MAT_SAND) begin
        if (grid_model[below] != MAT_SAND) begin
          grid_model[below] = MAT_SAND;
          grid_model[i] = MAT_EMPTY;
        end else if (col > 0 && grid_model[below - 1] != MAT_SAND) begin
          grid_model[below - 1] = MAT_SAND;
          grid_model[i] = MAT_EMPTY;
        end else if (col < SIDE - 1 && grid_model[below + 1] != MAT_SAND) begin
          grid_model[below + 1] = MAT_SAND;
          grid_model[i] = MAT_EMPTY;
        end
      end else if (grid_model[i] == MAT_WATER) begin
        if (grid_model[below] == MAT_EMPTY) begin
          grid_model[below] = MAT_WATER;
          grid_model[i] = MAT_EMPTY;
        end else if (col > 0 && grid_model[i - 1] == MAT_EMPTY) begin
          grid_model[i - 1] = MAT_WATER;
          grid_model[i] = MAT_EMPTY;
        end else if (col < SIDE - 1 && grid_model[i + 1] == MAT_EMPTY) begin
          grid_model[i + 1] = MAT_WATER;
          grid_model[i] = MAT_EMPTY;
        end
      end
    end
  endfunction

  function automatic res_t apply_cmd(cell_req_t c);
    res_t        r;
    int unsigned col;
    int unsigned idx;
    bit          row_ok;
    col = int'(c.col) % SIDE;
    row_ok = int'(c.row) < SIDE;
    idx = row_ok ? int'(c.row) * SIDE + col : 0;
    r.material = MAT_EMPTY;
    r.frame_done = 1'b0;
    if (c.func == FUNC_READ) begin
      if (row_ok) r.material = grid_model[idx];
    end else begin
      if (row_ok && c.sand) grid_model[idx] = MAT_SAND;
      if (row_ok && c.water) grid_model[idx] = MAT_WATER;
      sweep_grid();
      r.frame_done = 1'b1;
    end
    return r;
  endfunction

  function automatic int unsigned idle_pct(bit sender);
    if (n_sent < n_total / 3) return sender ? 29 : 83;
    if (n_sent < 2 * n_total / 3) return sender ? 83 : 29;
    return 0;
  endfunction

  function automatic void push_cmd(func_e f, int x, int y, bit sand, bit water);
    cell_req_t c;
    c.func = f;
    c.col = 6'(x);
    c.row = 6'(y);
    c.sand = sand;
    c.water = water;
    c.wait_idle = 1'b0;
    c.hold_rx = 1'b0;
    pending_cmds.push_back(c);
  endfunction

  // most transactions land near the bottom rows so piles and pools build up
  function automatic cell_req_t random_cmd(bit read_only);
    cell_req_t   c;
    int unsigned pick;
    c.func = (!read_only && $urandom_range(99) < 40) ? FUNC_FRAME : FUNC_READ;
    pick = $urandom_range(99);
    if (pick < 60) begin
      c.col = 6'($urandom_range(27, 18));
      c.row = 6'($urandom_range(63, 54));
    end else if (pick < 75) begin
      c.col = ($urandom_range(1) != 0) ? 6'($urandom_range(2)) : 6'($urandom_range(63, 61));
      c.row = 6'($urandom_range(63, 56));
    end else begin
      c.col = 6'($urandom);
      c.row = 6'($urandom);
    end
    c.sand = 1'($urandom_range(1));
    c.water = ($urandom_range(99) < 35);
    c.wait_idle = 1'b0;
    c.hold_rx = 1'b0;
    return c;
  endfunction

  // driver: valid stays up until the transaction is taken
  always @(posedge clk_i) begin : drive_proc
    bit take;
    bit hold_next;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      rx_hold_req <= 1'b0;
    end else begin
      take = s_valid && s_ready;
      hold_next = 1'b0;
      if (take) begin
        hold_next = pending_cmds[0].hold_rx;
        expected_cells.push_back(apply_cmd(pending_cmds[0]));
        void'(pending_cmds.pop_front());
        n_sent++;
      end
      rx_hold_req <= hold_next;
      if (!s_valid || take) begin
        if (pending_cmds.size() != 0
            && !(pending_cmds[0].wait_idle && expected_cells.size() != 0)
            && $urandom_range(99) >= idle_pct(1'b1)) begin
          s_valid <= 1'b1;
          s_data <= {2'b00, pending_cmds[0].water, pending_cmds[0].sand,
                     pending_cmds[0].row, pending_cmds[0].col};
          s_user <= pending_cmds[0].func;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      rx_hold_left <= 0;
    end else if (rx_hold_req) begin
      m_ready <= 1'b0;
      rx_hold_left <= HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      m_ready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      m_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk_i) begin : check_proc
    res_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected result transaction: cell_material %0d, frame_done %0d",
               m_data[1:0], m_user);
        mismatch_count++;
      end else begin
        want = expected_cells.pop_front();
        if (m_data[1:0] != want.material) begin
          $error("cell_material: expected %0d, actual %0d", want.material, m_data[1:0]);
          mismatch_count++;
        end
        if (m_user != want.frame_done) begin
          $error("frame_done: expected %0d, actual %0d", want.frame_done, m_user);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus_proc
    cell_req_t c;
    foreach (grid_model[i]) grid_model[i] = MAT_EMPTY;

    // empty grid, corners, sand onto water, both buttons, piles and spreading water
    push_cmd(FUNC_READ, 0, 0, 1'b0, 1'b0);
    push_cmd(FUNC_READ, 63, 63, 1'b1, 1'b1);
    push_cmd(FUNC_FRAME, 0, 63, 1'b1, 1'b0);
    push_cmd(FUNC_FRAME, 63, 63, 1'b0, 1'b1);
    push_cmd(FUNC_FRAME, 63, 62, 1'b1, 1'b0);
    push_cmd(FUNC_FRAME, 10, 62, 1'b1, 1'b1);
    push_cmd(FUNC_FRAME, 0, 62, 1'b1, 1'b0);
    push_cmd(FUNC_FRAME, 5, 5, 1'b0, 1'b0);
    push_cmd(FUNC_FRAME, 0, 0, 1'b1, 1'b0);
    push_cmd(FUNC_FRAME, 63, 0, 1'b0, 1'b1);
    push_cmd(FUNC_FRAME, 20, 63, 1'b1, 1'b0);
    push_cmd(FUNC_FRAME, 20, 62, 1'b1, 1'b0);
    push_cmd(FUNC_FRAME, 20, 62, 1'b1, 1'b0);
    push_cmd(FUNC_FRAME, 40, 63, 1'b0, 1'b1);
    push_cmd(FUNC_FRAME, 40, 62, 1'b0, 1'b1);
    push_cmd(FUNC_FRAME, 40, 62, 1'b0, 1'b1);
    push_cmd(FUNC_FRAME, 63, 62, 1'b0, 1'b1);
    push_cmd(FUNC_READ, 19, 63, 1'b0, 1'b0);
    push_cmd(FUNC_READ, 21, 63, 1'b0, 1'b0);
    push_cmd(FUNC_READ, 39, 62, 1'b0, 1'b0);
    push_cmd(FUNC_READ, 41, 62, 1'b0, 1'b0);
    push_cmd(FUNC_READ, 63, 63, 1'b0, 1'b0);
    push_cmd(FUNC_READ, 0, 2, 1'b0, 1'b0);

    // drain first, then a burst of reads against a receiver that holds off
    c = random_cmd(1'b1);
    c.wait_idle = 1'b1;
    c.hold_rx = 1'b1;
    pending_cmds.push_back(c);
    repeat (12) pending_cmds.push_back(random_cmd(1'b1));
    repeat (64) pending_cmds.push_back(random_cmd(1'b0));
    n_total = pending_cmds.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || s_valid || expected_cells.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
rtl/core/fsg_pkg.sv
rtl/core/fsg_engine.sv
rtl/core/falling_sand_grid_update_top.sv
rtl/core/fsg_checker.sv
sim/testbench.sv
